// File: src/rpr_pkg.sv
package rpr_pkg;

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_PROBE    = 2'd1;
   localparam logic [1:0] KIND_FEEDBACK = 2'd2;

   localparam logic [1:0] PORT_CW  = 2'd0;
   localparam logic [1:0] PORT_CCW = 2'd1;
   localparam logic [1:0] PORT_APP = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ADDRESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_INTERVAL = 2'd1;

   localparam logic [3:0] NODE_ADDRESS_RESET   = 4'd0;
   localparam logic [7:0] PROBE_INTERVAL_RESET = 8'd20;
   localparam logic [7:0] SENT_COUNT_MAX       = 8'hFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  destination;
      logic [3:0]  source;
      logic        arrival_gate;
      logic [15:0] byte_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  out_port;
      logic [1:0]  out_kind;
      logic [3:0]  out_source;
      logic [3:0]  out_destination;
      logic [15:0] out_length;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0] node_address;
      logic [7:0] probe_interval;
   } rpr_cfg_type;

   typedef struct packed {
      logic       preferred_direction;
      logic       probe_due;
      logic [7:0] sent_count;
   } rpr_state_type;

   typedef struct packed {
      rpr_state_type next_state;
      logic          seen_write;
      logic          seen_value;
   } rpr_update_type;

endpackage

// File: src/rpr_req_if.sv
interface rpr_req_if;
   import rpr_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/rpr_rsp_if.sv
interface rpr_rsp_if;
   import rpr_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/rpr_csr_if.sv
interface rpr_csr_if;
   import rpr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/rpr_route.sv
module rpr_route (
   input  rpr_pkg::req_item_type   item,
   input  rpr_pkg::rpr_cfg_type    cfg,
   input  rpr_pkg::rpr_state_type  state,
   input  logic                    seen_bit,
   input  logic [1:0]              phase,
   output logic [1:0]              count,
   output rpr_pkg::rsp_item_type   result,
   output rpr_pkg::rpr_update_type update
);
   import rpr_pkg::*;

   logic [1:0]   other_port;
   logic [1:0]   gate_port;
   logic [7:0]   base_count;
   logic [7:0]   next_count;
   rsp_item_type pass_item;
   rsp_item_type probe_item;

   assign other_port = {1'b0, ~item.arrival_gate};
   assign gate_port  = {1'b0, item.arrival_gate};

   always_comb begin
      pass_item.out_port        = other_port;
      pass_item.out_kind        = item.kind;
      pass_item.out_source      = item.source;
      pass_item.out_destination = item.destination;
      pass_item.out_length      = item.byte_length;
      pass_item.last            = 1'b1;

      probe_item.out_port        = PORT_CW;
      probe_item.out_kind        = KIND_PROBE;
      probe_item.out_source      = cfg.node_address;
      probe_item.out_destination = item.destination;
      probe_item.out_length      = item.byte_length;
      probe_item.last            = 1'b0;

      // Probes restart the count, so the counter then reads one after this request.
      base_count = state.probe_due ? 8'd0 : state.sent_count;
      next_count = (base_count == SENT_COUNT_MAX) ? base_count : base_count + 8'd1;

      count             = 2'd0;
      result            = pass_item;
      update.next_state = state;
      update.seen_write = 1'b0;
      update.seen_value = 1'b0;

      if (item.kind == KIND_PROBE || item.kind == KIND_FEEDBACK) begin
         if (item.destination != cfg.node_address) begin
            count = 2'd1;
         end else if (item.kind == KIND_FEEDBACK) begin
            update.next_state.preferred_direction = item.arrival_gate;
         end else begin
            update.seen_write = 1'b1;
            update.seen_value = ~seen_bit;
            if (!seen_bit) begin
               update.next_state.preferred_direction = ~item.arrival_gate;
               count                  = 2'd1;
               result.out_port        = gate_port;
               result.out_kind        = KIND_FEEDBACK;
               result.out_source      = item.destination;
               result.out_destination = item.source;
            end
         end
      end else if (item.destination == cfg.node_address) begin
         count           = 2'd1;
         result.out_port = PORT_APP;
      end else if (item.source == cfg.node_address) begin
         update.next_state.sent_count = next_count;
         update.next_state.probe_due  = (next_count > cfg.probe_interval);
         count           = state.probe_due ? 2'd3 : 2'd1;
         result.out_port = {1'b0, state.preferred_direction};
         // With probes due, the two probes lead and the data request follows.
         if (state.probe_due) begin
            case (phase)
               2'd0: begin
                  result = probe_item;
               end
               2'd1: begin
                  result          = probe_item;
                  result.out_port = PORT_CCW;
               end
               default: begin
                  result.out_port = {1'b0, state.preferred_direction};
               end
            endcase
         end
      end else begin
         count = 2'd1;
      end
   end

endmodule

// File: src/rpr_out_stage.sv
module rpr_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rpr_pkg::rsp_item_type push_item,
   rpr_rsp_if.source             rsp_bus
);
   import rpr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   rsp_item_type item_in;

   assign push_ready = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push_ready) begin
         valid_in = push_valid;
         if (push_valid) begin
            item_in = push_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_bus.valid   = valid_ff;
   assign rsp_bus.payload = item_ff;

endmodule

// File: src/ring_probe_router.sv
// Channel  Direction  Handshake      Payload
// req_bus  in         valid/ready    kind, destination, source, arrival_gate, byte_length
// rsp_bus  out        valid/ready    out_port, out_kind, out_source, out_destination,
//                                    out_length, last
// csr_bus  in         valid/ready    index, data (ready is always high)
//
// A request giving zero or one response retires with its response, if any, so one request a cycle
// is sustained while responses are not stalled. A data request that triggers probes gives three
// responses, sent one a cycle by the response register while rsp_bus.ready is high. Synchronous
// reset restores the control state, including the seen bits, but not the item registers. A stalled
// response register holds the request in the input register; req_bus.ready is low until it drains.
module ring_probe_router #(
   parameter int unsigned RING_NODES = 16
) (
   input logic     clock,
   input logic     reset,
   rpr_req_if.sink req_bus,
   rpr_rsp_if.source rsp_bus,
   rpr_csr_if.sink csr_bus
);
   import rpr_pkg::*;

   localparam int unsigned IDX_W = (RING_NODES > 1) ? $clog2(RING_NODES) : 1;

   logic           in_valid_ff;
   logic           in_valid_in;
   req_item_type   item_ff;
   req_item_type   item_in;
   logic [1:0]     phase_ff;
   logic [1:0]     phase_in;
   rpr_state_type  state_ff;
   rpr_state_type  state_in;
   rpr_cfg_type    cfg_ff;
   rpr_cfg_type    cfg_in;
   logic [RING_NODES-1:0] seen_ff;
   logic [RING_NODES-1:0] seen_in;

   logic [IDX_W-1:0] seen_slot [16];
   logic [IDX_W-1:0] seen_idx;
   logic [1:0]       route_count;
   rsp_item_type     push_item;
   rpr_update_type   route_update;
   logic             out_ready;
   logic             push;
   logic             last_slot;
   logic             consume;
   logic             probe_fire;

   // Every 4-bit source is folded onto the ring size through a small constant table.
   for (genvar g = 0; g < 16; g++) begin : g_seen_slot
      assign seen_slot[g] = IDX_W'(g % RING_NODES);
   end

   assign seen_idx = seen_slot[item_ff.source];

   rpr_route u_route (
      .item     (item_ff),
      .cfg      (cfg_ff),
      .state    (state_ff),
      .seen_bit (seen_ff[seen_idx]),
      .phase    (phase_ff),
      .count    (route_count),
      .result   (push_item),
      .update   (route_update)
   );

   rpr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push),
      .push_ready (out_ready),
      .push_item  (push_item),
      .rsp_bus    (rsp_bus)
   );

   assign last_slot  = (phase_ff == route_count - 2'd1);
   assign push       = in_valid_ff && (route_count != 2'd0) && out_ready;
   assign consume    = in_valid_ff && ((route_count == 2'd0) || (push && last_slot));
   assign probe_fire = (route_count == 2'd3);

   assign req_bus.ready = !in_valid_ff || consume;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      phase_in    = phase_ff;
      state_in    = state_ff;
      seen_in     = seen_ff;
      cfg_in      = cfg_ff;

      if (push) begin
         phase_in = last_slot ? 2'd0 : phase_ff + 2'd1;
      end
      if (consume) begin
         in_valid_in = 1'b0;
         state_in    = route_update.next_state;
         if (route_update.seen_write) begin
            seen_in[seen_idx] = route_update.seen_value;
         end
      end
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
         item_in     = req_bus.payload;
      end

      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_NODE_ADDRESS:   cfg_in.node_address   = csr_bus.data[3:0];
            CSR_PROBE_INTERVAL: cfg_in.probe_interval = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         phase_ff                     <= 2'd0;
         state_ff.preferred_direction <= 1'b0;
         state_ff.probe_due           <= 1'b1;
         state_ff.sent_count          <= 8'd0;
         seen_ff                      <= '0;
         cfg_ff.node_address          <= NODE_ADDRESS_RESET;
         cfg_ff.probe_interval        <= PROBE_INTERVAL_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         state_ff    <= state_in;
         seen_ff     <= seen_in;
         cfg_ff      <= cfg_in;
      end
      item_ff <= item_in;
   end

`ifndef SYNTHESIS
   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && phase_ff != 2'd0 |-> phase_ff < route_count)
      else $error("response slot beyond the responses of the held request");

   a_consume_on_last: assert property (@(posedge clock) disable iff (reset)
      consume && route_count != 2'd0 |-> push && push_item.last)
      else $error("request retired before its last response was sent");

   a_not_last_keeps: assert property (@(posedge clock) disable iff (reset)
      push && !push_item.last |=> in_valid_ff && phase_ff == $past(phase_ff) + 2'd1)
      else $error("request lost between its responses");

   a_probe_restarts: assert property (@(posedge clock) disable iff (reset)
      consume && probe_fire |=> state_ff.sent_count == 8'd1)
      else $error("sent count not restarted after probing");
`endif

endmodule
